// ----- rtl/core/ilp_pkg.sv -----
// Shared types, constants and character helpers for the integer literal parser.
// Used by every module of the parser; depends on nothing else.
package ilp_pkg;

    localparam int MAX_COUNT   = 127;
    localparam int CNT_W       = $clog2(MAX_COUNT + 1);
    localparam int CHAR_W      = 8;
    localparam int VALUE_W     = 64;
    localparam int COUNT_OUT_W = 7;
    localparam int DIGIT_W     = 4;
    localparam int DATA_OUT_W  = ((VALUE_W + COUNT_OUT_W + 7) / 8) * 8;
    localparam int PHASE_W     = 3;

    localparam logic [PHASE_W-1:0] PH_START     = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SIGNED    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ZERO      = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DIGITS    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_HEX_START = 3'd4;

    localparam logic [CHAR_W-1:0] CH_PLUS       = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS      = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_LOWER_X    = 8'h78;
    localparam logic [CHAR_W-1:0] CH_ZERO       = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE       = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LOWER_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_F    = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UPPER_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_F    = 8'h46;
    localparam logic [CHAR_W-1:0] LOWER_BIAS    = 8'h57;
    localparam logic [CHAR_W-1:0] UPPER_BIAS    = 8'h37;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              end_of_text;
    } ilp_item_t;

    typedef struct packed {
        logic                   emit;
        logic                   literal_valid;
        logic [VALUE_W-1:0]     literal_value;
        logic [COUNT_OUT_W-1:0] chars_consumed;
    } ilp_result_t;

    typedef struct packed {
        logic               ok;
        logic [DIGIT_W-1:0] val;
    } ilp_digit_t;

    function automatic ilp_digit_t dec_digit(input logic [CHAR_W-1:0] c);
        ilp_digit_t        r;
        logic [CHAR_W-1:0] t;
        t     = c - CH_ZERO;
        r.ok  = (c >= CH_ZERO) && (c <= CH_NINE);
        r.val = t[DIGIT_W-1:0];
        return r;
    endfunction

    function automatic ilp_digit_t hex_digit(input logic [CHAR_W-1:0] c);
        ilp_digit_t        r;
        logic [CHAR_W-1:0] t;
        r.ok = 1'b1;
        if ((c >= CH_ZERO) && (c <= CH_NINE))
        begin
            t = c - CH_ZERO;
        end
        else if ((c >= CH_LOWER_A) && (c <= CH_LOWER_F))
        begin
            t = c - LOWER_BIAS;
        end
        else if ((c >= CH_UPPER_A) && (c <= CH_UPPER_F))
        begin
            t = c - UPPER_BIAS;
        end
        else
        begin
            t    = '0;
            r.ok = 1'b0;
        end
        r.val = t[DIGIT_W-1:0];
        return r;
    endfunction

endpackage

// ----- rtl/core/ilp_in_reg.sv -----
// Input register of the integer literal parser: holds one character transfer.
// Depends on ilp_pkg.
module ilp_in_reg
    import ilp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CHAR_W-1:0] s_tdata,
    input  logic              s_tlast,
    input  logic              pop,
    output logic              item_valid,
    output ilp_item_t         item
);

    logic      valid_reg;
    logic      valid_next;
    ilp_item_t item_reg;
    logic      load;

    assign s_tready   = !valid_reg || pop;
    assign load       = s_tvalid && s_tready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.char_code   <= s_tdata;
            item_reg.end_of_text <= s_tlast;
        end
    end

endmodule

// ----- rtl/core/ilp_parser.sv -----
// Parse state and one-character step of the integer literal parser.
// Depends on ilp_pkg.
module ilp_parser
    import ilp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  ilp_item_t   item,
    input  logic        out_free,
    output logic        pop,
    output ilp_result_t result
);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic               has_digit_reg, has_digit_next;
    logic               neg_reg, neg_next;
    logic               hex_reg, hex_next;
    logic               upend_reg, upend_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic [CNT_W-1:0]               count_inc;
    logic [CNT_W+COUNT_OUT_W-1:0]   count_wide;
    logic [CHAR_W-1:0]              c;
    ilp_digit_t                     dd;
    ilp_digit_t                     hd;
    ilp_digit_t                     rd;
    logic [VALUE_W-1:0]             scaled;
    logic [VALUE_W-1:0]             dterm;
    logic [VALUE_W-1:0]             acc_add;
    logic                           emit;
    logic                           emit_ok;

    // The accumulator carries the sign from the start: a negative literal
    // subtracts each digit, so the stored value is already the result.
    assign c         = item.char_code;
    assign dd        = dec_digit(c);
    assign hd        = hex_digit(c);
    assign rd        = hex_reg ? hd : dd;
    assign count_inc = (count_reg < CNT_W'(MAX_COUNT)) ? count_reg + 1'b1 : count_reg;
    assign scaled    = hex_reg ? {acc_reg[VALUE_W-5:0], 4'b0000}
                               : ({acc_reg[VALUE_W-4:0], 3'b000} + {acc_reg[VALUE_W-2:0], 1'b0});
    assign dterm     = neg_reg ? (VALUE_W'(0) - VALUE_W'(rd.val)) : VALUE_W'(rd.val);
    assign acc_add   = scaled + dterm;

    always_comb
    begin
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        has_digit_next = has_digit_reg;
        neg_next       = neg_reg;
        hex_next       = hex_reg;
        upend_next     = upend_reg;
        count_next     = count_reg;
        emit           = 1'b0;
        emit_ok        = 1'b0;

        unique case (phase_reg) inside
            PH_ZERO, PH_DIGITS:
            begin
                if ((phase_reg == PH_ZERO) && (c == CH_LOWER_X))
                begin
                    count_next     = count_inc;
                    hex_next       = 1'b1;
                    has_digit_next = 1'b0;
                    acc_next       = '0;
                    phase_next     = PH_HEX_START;
                end
                else
                begin
                    phase_next = PH_DIGITS;
                    if (upend_reg)
                    begin
                        if (!rd.ok)
                        begin
                            emit = 1'b1;
                        end
                        else
                        begin
                            count_next     = count_inc;
                            acc_next       = acc_add;
                            has_digit_next = 1'b1;
                            upend_next     = 1'b0;
                        end
                    end
                    else if (rd.ok)
                    begin
                        count_next     = count_inc;
                        acc_next       = acc_add;
                        has_digit_next = 1'b1;
                    end
                    else if (c == CH_UNDERSCORE)
                    begin
                        count_next = count_inc;
                        upend_next = 1'b1;
                    end
                    else
                    begin
                        emit    = 1'b1;
                        emit_ok = 1'b1;
                    end
                end
            end
            PH_HEX_START:
            begin
                if (!hd.ok)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    count_next     = count_inc;
                    acc_next       = acc_add;
                    has_digit_next = 1'b1;
                    phase_next     = PH_DIGITS;
                end
            end
            default:
            begin
                if ((phase_reg != PH_SIGNED) && ((c == CH_PLUS) || (c == CH_MINUS)))
                begin
                    count_next = count_inc;
                    neg_next   = (c == CH_MINUS);
                    phase_next = PH_SIGNED;
                end
                else if (!dd.ok)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    count_next     = count_inc;
                    acc_next       = dterm;
                    has_digit_next = 1'b1;
                    phase_next     = (dd.val == '0) ? PH_ZERO : PH_DIGITS;
                end
            end
        endcase

        if (!emit && item.end_of_text)
        begin
            emit    = 1'b1;
            emit_ok = ((phase_next == PH_ZERO) || (phase_next == PH_DIGITS))
                      && has_digit_next && !upend_next;
        end
    end

    assign count_wide = {{COUNT_OUT_W{1'b0}}, count_next};

    assign result.emit           = emit;
    assign result.literal_valid  = emit_ok;
    assign result.literal_value  = emit_ok ? acc_next : '0;
    assign result.chars_consumed = emit_ok ? count_wide[COUNT_OUT_W-1:0] : '0;

    assign pop = item_valid && (!emit || out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            acc_reg       <= '0;
            has_digit_reg <= 1'b0;
            neg_reg       <= 1'b0;
            hex_reg       <= 1'b0;
            upend_reg     <= 1'b0;
            count_reg     <= '0;
        end
        else if (pop)
        begin
            if (emit)
            begin
                phase_reg     <= PH_START;
                acc_reg       <= '0;
                has_digit_reg <= 1'b0;
                neg_reg       <= 1'b0;
                hex_reg       <= 1'b0;
                upend_reg     <= 1'b0;
                count_reg     <= '0;
            end
            else
            begin
                phase_reg     <= phase_next;
                acc_reg       <= acc_next;
                has_digit_reg <= has_digit_next;
                neg_reg       <= neg_next;
                hex_reg       <= hex_next;
                upend_reg     <= upend_next;
                count_reg     <= count_next;
            end
        end
    end

endmodule

// ----- rtl/core/integer_literal_parser_core.sv -----
// Top level of the integer literal parser: input register, parse step and
// result register. Depends on ilp_pkg, ilp_in_reg and ilp_parser.

// The block takes one character per transfer and returns one result for each
// literal, on the character where its outcome is known or at end of text.
// Each character is parsed combinationally between the input register and the
// result register, so a new character is taken every cycle; the only limit is
// a result that is still waiting on the output, which holds the character that
// would produce the next result.
module integer_literal_parser_core
    import ilp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [CHAR_W-1:0]     s_tdata,  // [7:0] char_code
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_OUT_W-1:0] m_tdata,  // [63:0] literal_value, [70:64] chars_consumed
    output logic                  m_tuser   // [0] literal_valid
);

    logic        item_valid;
    ilp_item_t   item;
    logic        pop;
    logic        out_free;
    ilp_result_t result;

    logic                  out_valid_reg, out_valid_next;
    logic [DATA_OUT_W-1:0] out_data_reg;
    logic                  out_user_reg;
    logic                  out_load;

    ilp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .pop        (pop),
        .item_valid (item_valid),
        .item       (item)
    );

    ilp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .pop        (pop),
        .result     (result)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign out_load = pop && result.emit;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= DATA_OUT_W'({result.chars_consumed, result.literal_value});
            out_user_reg <= result.literal_valid;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    a_no_lost_result : assert property (@(posedge clk) disable iff (!rst_n)
        (pop && result.emit) |-> out_free)
        else $error("A result was loaded over one still waiting.");

    a_stall_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> item_valid)
        else $error("Input stalled with an empty input register.");

    a_invalid_is_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("An invalid result carries a nonzero payload.");

    a_result_follows_pop : assert property (@(posedge clk) disable iff (!rst_n)
        (pop && result.emit) |=> m_tvalid)
        else $error("A finished literal did not reach the output.");

endmodule
